// ===== sv/gps_utc_time_anchor_top_assert.svh =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor assertion macros
// Concurrent check helpers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GPS_UTC_TIME_ANCHOR_TOP_ASSERT_SVH
`define GPS_UTC_TIME_ANCHOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define GUTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gutc assertion failed");
`define GUTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gutc assertion failed");
`else
`define GUTC_ASSERT_IMP(lbl, ante, cons)
`define GUTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/gutc_pkg.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor package
// Shared constants, queue entry type and calendar helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gutc_pkg;

    localparam int GUTC_QUEUE_DEPTH = 2;

    localparam logic [15:0] FRESH_AGE_LIMIT_RST = 16'd5000;
    localparam logic [31:0] RESYNC_INTERVAL_RST = 32'd30000;

    localparam logic [12:0] ERA_RECIP        = 13'd5243;
    localparam int          ERA_RECIP_SHIFT  = 21;
    localparam logic signed [12:0] YEARS_PER_ERA = 13'sd400;
    localparam logic signed [21:0] ERA_DAYS      = 22'sd146097;
    localparam logic signed [21:0] EPOCH_SHIFT   = 22'sd719468;
    localparam logic signed [27:0] MS_PER_DAY    = 28'sd86400000;

    typedef enum logic {
        CFG_FRESH_AGE_LIMIT = 1'b0,
        CFG_RESYNC_INTERVAL = 1'b1
    } gutc_cfg_idx_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [31:0] fix_age_ms;
        logic        eligible;
        logic [47:0] fresh_ms;
    } gutc_entry_t;

    // days before the start of a March-based month
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // year of era divided by 100
    function automatic logic [1:0] centuries(input logic [8:0] yoe);
        logic [1:0] r;
        if (yoe >= 9'd300)
            r = 2'd3;
        else if (yoe >= 9'd200)
            r = 2'd2;
        else if (yoe >= 9'd100)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

endpackage

// ===== sv/gutc_front.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor front end
// Takes one input transaction, converts the civil date to epoch ms over a
// short step sequence, qualifies it and pushes it into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gutc_front import gutc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       now_ms,
    input  logic              utc_valid,
    input  logic [11:0]       year,
    input  logic [3:0]        month,
    input  logic [4:0]        day,
    input  logic [4:0]        hour,
    input  logic [5:0]        minute,
    input  logic [5:0]        second,
    input  logic [6:0]        centisecond,
    input  logic [31:0]       fix_age_ms,
    input  logic [15:0]       fresh_age_limit_ms,
    input  logic              q_full,
    output logic              q_push,
    output gutc_entry_t       q_entry
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERA,
        S_YOE,
        S_DOE,
        S_DAYS,
        S_MS,
        S_SUM,
        S_PUSH
    } state_t;

    state_t state_reg;

    logic [31:0]        now_reg;
    logic [31:0]        age_reg;
    logic               valid_reg;
    logic signed [12:0] y_reg;
    logic [3:0]         mp_reg;
    logic [4:0]         day_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         minute_reg;
    logic [5:0]         second_reg;
    logic [6:0]         cs_reg;
    logic [25:0]        q_reg;
    logic [27:0]        tod_reg;
    logic signed [9:0]  doy_reg;
    logic signed [4:0]  era_reg;
    logic [8:0]         yoe_reg;
    logic signed [18:0] doe_reg;
    logic signed [21:0] days_reg;
    logic [47:0]        dms_reg;
    gutc_entry_t        entry_reg;

    logic               accept;
    logic [12:0]        y_biased;
    logic signed [4:0]  era_n;
    logic signed [12:0] era_years;
    logic signed [18:0] yoe_s;
    logic signed [47:0] days_ms;
    logic [47:0]        fresh_ms;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign q_push   = (state_reg == S_PUSH) && !q_full;
    assign q_entry  = entry_reg;

    always_comb
    begin
        y_biased  = 13'(y_reg + YEARS_PER_ERA);
        era_n     = signed'(5'(q_reg[25:ERA_RECIP_SHIFT])) - 5'sd1;
        era_years = 13'(era_n) * YEARS_PER_ERA;
        yoe_s     = signed'({10'b0, yoe_reg});
        days_ms   = days_reg * MS_PER_DAY;
        fresh_ms  = 48'(dms_reg + {20'b0, tod_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:  if (accept) state_reg <= S_ERA;
                S_ERA:   state_reg <= S_YOE;
                S_YOE:   state_reg <= S_DOE;
                S_DOE:   state_reg <= S_DAYS;
                S_DAYS:  state_reg <= S_MS;
                S_MS:    state_reg <= S_SUM;
                S_SUM:   state_reg <= S_PUSH;
                S_PUSH:  if (!q_full) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_reg    <= now_ms;
                    age_reg    <= fix_age_ms;
                    valid_reg  <= utc_valid;
                    y_reg      <= signed'({1'b0, year}) - ((month <= 4'd2) ? 13'sd1 : 13'sd0);
                    mp_reg     <= (month > 4'd2) ? 4'(month - 4'd3) : 4'(month + 4'd9);
                    day_reg    <= day;
                    hour_reg   <= hour;
                    minute_reg <= minute;
                    second_reg <= second;
                    cs_reg     <= centisecond;
                end
            end
            S_ERA:
            begin
                q_reg   <= {13'b0, y_biased} * {13'b0, ERA_RECIP};
                tod_reg <= 28'(hour_reg) * 28'd3600000 + 28'(minute_reg) * 28'd60000
                         + 28'(second_reg) * 28'd1000 + 28'(cs_reg) * 28'd10;
                doy_reg <= signed'({1'b0, month_offset(mp_reg)})
                         + signed'({5'b0, day_reg}) - 10'sd1;
            end
            S_YOE:
            begin
                era_reg <= era_n;
                yoe_reg <= 9'(y_reg - era_years);
            end
            S_DOE:
            begin
                doe_reg <= yoe_s * 19'sd365 + (yoe_s >>> 2)
                         - signed'({17'b0, centuries(yoe_reg)}) + 19'(doy_reg);
            end
            S_DAYS:
            begin
                days_reg <= 22'(era_reg) * ERA_DAYS + 22'(doe_reg) - EPOCH_SHIFT;
            end
            S_MS:
            begin
                dms_reg <= days_ms;
            end
            S_SUM:
            begin
                entry_reg.now_ms     <= now_reg;
                entry_reg.fix_age_ms <= age_reg;
                entry_reg.fresh_ms   <= fresh_ms;
                entry_reg.eligible   <= valid_reg && (age_reg < {16'b0, fresh_age_limit_ms})
                                        && (fresh_ms != 48'd0);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/gutc_queue.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor queue
// Small register FIFO between the conversion front end and the anchor stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gutc_queue import gutc_pkg::*;
#(
    parameter int DEPTH = GUTC_QUEUE_DEPTH   // 2 or more
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  gutc_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output gutc_entry_t pop_entry,
    output logic        empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gutc_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/gutc_back.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor back end
// Applies the resync decision, holds the anchor and projects epoch ms into
// the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gutc_back import gutc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  gutc_entry_t q_entry,
    output logic        q_pop,
    input  logic [31:0] resync_interval_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] epoch_ms,
    output logic        resynced
);

    logic [47:0] utc_anchor_reg;
    logic [31:0] counter_anchor_reg;
    logic [31:0] last_sync_reg;
    logic        out_valid_reg;
    logic [47:0] epoch_reg;
    logic        resynced_reg;

    logic [31:0] since_sync;
    logic        sync_due;
    logic        resync;
    logic [47:0] anchor_sel;
    logic [31:0] elapsed;
    logic [47:0] epoch_next;

    assign q_pop     = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign epoch_ms  = epoch_reg;
    assign resynced  = resynced_reg;

    always_comb
    begin
        since_sync = q_entry.now_ms - last_sync_reg;
        sync_due   = (last_sync_reg == 32'd0) || (since_sync >= resync_interval_ms);
        resync     = q_entry.eligible && sync_due;
        anchor_sel = resync ? q_entry.fresh_ms : utc_anchor_reg;
        // on a resync the elapsed counter time is exactly the fix age
        elapsed    = resync ? q_entry.fix_age_ms : q_entry.now_ms - counter_anchor_reg;
        epoch_next = (anchor_sel == 48'd0) ? 48'd0 : 48'(anchor_sel + {16'b0, elapsed});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_anchor_reg     <= '0;
            counter_anchor_reg <= '0;
            last_sync_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                if (resync)
                begin
                    utc_anchor_reg     <= q_entry.fresh_ms;
                    counter_anchor_reg <= q_entry.now_ms - q_entry.fix_age_ms;
                    last_sync_reg      <= q_entry.now_ms;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            epoch_reg    <= epoch_next;
            resynced_reg <= resync;
        end
    end

endmodule

// ===== sv/gps_utc_time_anchor_top.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor
// Anchors a free-running ms counter to GPS UTC and projects Unix epoch ms.
//
// Input stream (s_axis): one transaction per GPS time sample, carrying the
// local counter, the civil date and time and the fix age; tuser is the
// time-valid flag. Output stream (m_axis): one transaction per input with
// the projected epoch ms in tdata and the resync flag in tuser.
// Configuration writes (age limit, resync interval) go over the cfg channel,
// which is always ready; write only while the block is idle.
// The front end takes a new transaction only once the previous one has been
// pushed: its date conversion sequencer steps through the era, year-of-era,
// day-of-era, day count, ms and sum states, then waits in the push state
// until the queue has room.
// A stalled receiver holds the output register; the queue and front end go
// on until both fill, then s_axis_tready stays low.
// Reset clears the anchor (output reads 0 until the first valid sync) and
// restores the default register values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gps_utc_time_anchor_top_assert.svh"

module gps_utc_time_anchor_top import gutc_pkg::*;
#(
    parameter int QUEUE_DEPTH = GUTC_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_ms[31:0], year[43:32], month[47:44], day[52:48], hour[57:53],
    // minute[63:58], second[69:64], centisecond[76:70], fix_age_ms[108:77]
    input  logic [111:0] s_axis_tdata,
    // utc_valid[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // epoch_ms[47:0]
    output logic [47:0]  m_axis_tdata,
    // resynced[0]
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [15:0] fresh_age_limit_reg;
    logic [31:0] resync_interval_reg;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    gutc_entry_t push_entry;
    gutc_entry_t pop_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_age_limit_reg <= FRESH_AGE_LIMIT_RST;
            resync_interval_reg <= RESYNC_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (gutc_cfg_idx_t'(cfg_index))
                CFG_FRESH_AGE_LIMIT: fresh_age_limit_reg <= cfg_data[15:0];
                CFG_RESYNC_INTERVAL: resync_interval_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gutc_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .now_ms             (s_axis_tdata[31:0]),
        .utc_valid          (s_axis_tuser),
        .year               (s_axis_tdata[43:32]),
        .month              (s_axis_tdata[47:44]),
        .day                (s_axis_tdata[52:48]),
        .hour               (s_axis_tdata[57:53]),
        .minute             (s_axis_tdata[63:58]),
        .second             (s_axis_tdata[69:64]),
        .centisecond        (s_axis_tdata[76:70]),
        .fix_age_ms         (s_axis_tdata[108:77]),
        .fresh_age_limit_ms (fresh_age_limit_reg),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_entry            (push_entry)
    );

    gutc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    gutc_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .q_entry            (pop_entry),
        .q_pop              (q_pop),
        .resync_interval_ms (resync_interval_reg),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .epoch_ms           (m_axis_tdata),
        .resynced           (m_axis_tuser)
    );

    `GUTC_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `GUTC_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `GUTC_ASSERT_NEXT(a_front_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `GUTC_ASSERT_IMP(a_queue_state_sane, q_push || q_pop || 1'b1, !(q_full && q_empty))

endmodule

// ===== tb/sv/epoch_ms_checker.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor result checker
// Watches the config, input and output channels, predicts the projected
// epoch ms and resync flag of every accepted input transaction, and compares
// each output transaction against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_ms_checker import gutc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [47:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           outstanding,
    output int           results_checked,
    output int           resyncs_seen
);

    typedef struct packed {
        bit [47:0] epoch_ms;
        bit        resynced;
    } epoch_due_t;

    epoch_due_t epoch_due[$];

    bit [15:0] age_limit;
    bit [31:0] resync_gap;
    bit [47:0] anchor_utc_ms;
    bit [31:0] anchor_count;
    bit [31:0] last_sync_ms;

    // days-from-civil, March-based years, signed throughout
    function automatic bit [47:0] civil_ms(input bit [11:0] yr, input bit [3:0] mo,
                                           input bit [4:0] dy, input bit [4:0] hr,
                                           input bit [5:0] mi, input bit [5:0] sc,
                                           input bit [6:0] cs);
        longint y, m, d, era, yoe, mp, doy, doe, days, secs, ms;
        y = longint'(yr);
        m = longint'(mo);
        d = longint'(dy);
        if (m <= 2)
            y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        secs = days * 86400 + longint'(hr) * 3600 + longint'(mi) * 60 + longint'(sc);
        ms = secs * 1000 + longint'(cs) * 10;
        return ms[47:0];
    endfunction

    function automatic epoch_due_t project_epoch(input logic [111:0] fields,
                                                 input logic valid);
        epoch_due_t due;
        bit [31:0]  now;
        bit [31:0]  age;
        bit [31:0]  elapsed;
        bit [47:0]  fresh;
        now = fields[31:0];
        age = fields[108:77];
        due.resynced = 1'b0;
        if (valid && age < {16'd0, age_limit} &&
            (last_sync_ms == 32'd0 || (now - last_sync_ms) >= resync_gap))
        begin
            fresh = civil_ms(fields[43:32], fields[47:44], fields[52:48], fields[57:53],
                             fields[63:58], fields[69:64], fields[76:70]);
            if (fresh != 48'd0)
            begin
                anchor_utc_ms = fresh;
                anchor_count = now - age;
                last_sync_ms = now;
                due.resynced = 1'b1;
            end
        end
        elapsed = now - anchor_count;
        due.epoch_ms = (anchor_utc_ms == 48'd0) ? 48'd0 : anchor_utc_ms + {16'd0, elapsed};
        return due;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        epoch_due_t want;
        if (!rst_n)
        begin
            age_limit = 16'd5000;
            resync_gap = 32'd30000;
            anchor_utc_ms = '0;
            anchor_count = '0;
            last_sync_ms = '0;
            epoch_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (gutc_cfg_idx_t'(cfg_index))
                    CFG_FRESH_AGE_LIMIT: age_limit = cfg_data[15:0];
                    CFG_RESYNC_INTERVAL: resync_gap = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (epoch_due.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected result: epoch_ms %0d resynced %0b",
                           m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = epoch_due.pop_front();
                    if (m_axis_tdata !== want.epoch_ms)
                    begin
                        fail_count++;
                        $error("epoch_ms: expected %0d, actual %0d", want.epoch_ms, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.resynced)
                    begin
                        fail_count++;
                        $error("resynced: expected %0b, actual %0b", want.resynced, m_axis_tuser);
                    end
                    if (want.resynced)
                        resyncs_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                epoch_due.push_back(project_epoch(s_axis_tdata, s_axis_tuser));
        end
        outstanding = epoch_due.size();
    end

endmodule

// ===== tb/sv/tb_gps_utc_time_anchor_top.sv =====
// ---------------------------------------------------------------------------
// GPS UTC time anchor testbench
// Directed samples for the calendar and anchoring corner cases, then random
// GPS samples over several register settings, with random idling on both
// streams and one long receiver hold-off. Checking is done by the checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gps_utc_time_anchor_top;
    import gutc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        bit [31:0] now_ms;
        bit        utc_valid;
        bit [11:0] year;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
        bit [6:0]  centisecond;
        bit [31:0] fix_age_ms;
    } gps_sample_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    int fail_count;
    int outstanding;
    int results_checked;
    int resyncs_seen;

    int        cycle_count;
    int        samples_sent;
    int        settings_used;
    int        blocked_cycles;
    bit        gap_on;
    bit        quiet_tail;
    bit        hold_req;
    bit [31:0] sim_ms;

    gps_utc_time_anchor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    epoch_ms_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .resyncs_seen    (resyncs_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic send_sample(input gps_sample_t smp);
        int gap;
        if (gap_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = smp.utc_valid;
        s_axis_tdata = {3'b000, smp.fix_age_ms, smp.centisecond, smp.second, smp.minute,
                        smp.hour, smp.day, smp.month, smp.year, smp.now_ms};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            blocked_cycles++;
            @(posedge clk);
        end
        samples_sent++;
    endtask

    task automatic offer(input bit [31:0] now, input bit valid, input bit [11:0] yr,
                         input bit [3:0] mo, input bit [4:0] dy, input bit [4:0] hr,
                         input bit [5:0] mi, input bit [5:0] sc, input bit [6:0] cs,
                         input bit [31:0] age);
        gps_sample_t smp;
        smp.now_ms = now;
        smp.utc_valid = valid;
        smp.year = yr;
        smp.month = mo;
        smp.day = dy;
        smp.hour = hr;
        smp.minute = mi;
        smp.second = sc;
        smp.centisecond = cs;
        smp.fix_age_ms = age;
        send_sample(smp);
    endtask

    // mostly a steady GPS feed on an advancing counter, some raw noise
    task automatic make_sample(output gps_sample_t smp);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            smp.now_ms = $urandom;
            smp.utc_valid = 1'($urandom_range(0, 1));
            smp.year = 12'($urandom_range(0, 4095));
            smp.month = 4'($urandom_range(0, 15));
            smp.day = 5'($urandom_range(0, 31));
            smp.hour = 5'($urandom_range(0, 31));
            smp.minute = 6'($urandom_range(0, 63));
            smp.second = 6'($urandom_range(0, 63));
            smp.centisecond = 7'($urandom_range(0, 127));
            smp.fix_age_ms = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000);
        end
        else
        begin
            if ($urandom_range(0, 15) == 0)
                sim_ms += $urandom_range(20000, 200000);
            else
                sim_ms += $urandom_range(0, 3000);
            smp.now_ms = sim_ms;
            smp.utc_valid = ($urandom_range(0, 7) != 0);
            smp.year = 12'($urandom_range(1970, 2099));
            smp.month = 4'($urandom_range(1, 12));
            smp.day = 5'($urandom_range(1, 31));
            smp.hour = 5'($urandom_range(0, 23));
            smp.minute = 6'($urandom_range(0, 59));
            smp.second = 6'($urandom_range(0, 59));
            smp.centisecond = 7'($urandom_range(0, 99));
            smp.fix_age_ms = (pick == 1) ? $urandom : $urandom_range(0, 7000);
        end
    endtask

    task automatic run_random(input int count, input int quiet_after);
        gps_sample_t smp;
        sim_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_8000;
        for (int i = 0; i < count; i++)
        begin
            if (i == quiet_after)
                quiet_tail = 1'b1;
            make_sample(smp);
            send_sample(smp);
        end
    endtask

    task automatic write_reg(input gutc_cfg_idx_t idx, input bit [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_and_configure(input bit [15:0] limit, input bit [31:0] interval);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_FRESH_AGE_LIMIT, {16'd0, limit});
        write_reg(CFG_RESYNC_INTERVAL, interval);
        settings_used++;
    endtask

    // receiver: random stall bursts, calm stretches, one long hold-off
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (calm_left > 0)
                calm_left--;
            if (stall_left > 0)
                stall_left--;
            else if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (!quiet_tail && calm_left == 0)
            begin
                if ($urandom_range(0, 40) == 0)
                    calm_left = $urandom_range(50, 150);
                else if ($urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 10);
            end
            m_axis_tready = (stall_left == 0);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRESH_AGE_LIMIT;
        cfg_data = '0;
        gap_on = 1'b0;
        quiet_tail = 1'b0;
        hold_req = 1'b0;
        samples_sent = 0;
        settings_used = 1;
        blocked_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        offer(32'd1000, 1'b0, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd45, 7'd50, 32'd0);
        offer(32'd2000, 1'b1, 12'd2024, 4'd6, 5'd15, 5'd12, 6'd30, 6'd45, 7'd50, 32'd5000);
        offer(32'd3000, 1'b1, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 32'd0);
        offer(32'd4000, 1'b1, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 7'd99, 32'd4999);
        offer(32'd5000, 1'b1, 12'd2024, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 32'd0);
        offer(32'd34000, 1'b1, 12'd2024, 4'd2, 5'd29, 5'd6, 6'd7, 6'd8, 7'd9, 32'd100);
        offer(32'd64000, 1'b1, 12'd2000, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 7'd0, 32'd10);
        offer(32'd94000, 1'b1, 12'd2000, 4'd13, 5'd5, 5'd1, 6'd2, 6'd3, 7'd4, 32'd0);
        offer(32'd124000, 1'b1, 12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 7'd99, 32'd0);
        offer(32'd154000, 1'b1, 12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 32'd0);
        offer(32'd184000, 1'b1, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 7'd127, 32'd0);
        offer(32'd214000, 1'b0, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 7'd127,
              32'hFFFF_FFFF);
        // sync at counter zero leaves the block looking unsynced
        offer(32'd0, 1'b1, 12'd2023, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 32'd0);
        offer(32'd10, 1'b1, 12'd2023, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 7'd1, 32'd0);
        offer(32'hFFFF_FFF0, 1'b1, 12'd2030, 4'd7, 5'd4, 5'd12, 6'd0, 6'd0, 7'd0, 32'd20);
        offer(32'h0000_0100, 1'b0, 12'd2030, 4'd7, 5'd4, 5'd12, 6'd0, 6'd0, 7'd0, 32'd0);
        offer(32'h0000_0200, 1'b1, 12'd2031, 4'd8, 5'd9, 5'd10, 6'd11, 6'd12, 7'd13,
              32'hFFFF_FFFF);

        gap_on = 1'b1;
        drain_and_configure(16'hFFFF, 32'd0);
        run_random(90, -1);
        drain_and_configure(16'd0, 32'hFFFF_FFFF);
        run_random(50, -1);
        drain_and_configure(16'($urandom_range(1000, 65535)), $urandom_range(0, 20000));
        hold_req = 1'b1;
        run_random(110, -1);
        drain_and_configure(16'($urandom_range(0, 65535)), $urandom);
        gap_on = 1'b0;
        run_random(60, -1);
        gap_on = 1'b1;
        drain_and_configure(16'd5000, 32'd30000);
        run_random(140, 70);

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d GPS samples over %0d register settings.",
                 samples_sent, settings_used);
        $display("%0d results checked, %0d re-anchors, %0d cycles of input back-pressure.",
                 results_checked, resyncs_seen, blocked_cycles);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
